>>> hdl/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared widths, latency and stage carry type of the triangle unit normal.
// ----------------------------------------------------------------------------
package tun_pkg;

	localparam int COORD_BITS       = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int OUT_BITS         = NORMAL_FRAC_BITS + 2;
	localparam int DIFF_BITS        = COORD_BITS + 1;
	localparam int PROD_BITS        = 2 * DIFF_BITS;
	localparam int CROSS_BITS       = 2 * COORD_BITS + 2;
	localparam int MAG_BITS         = CROSS_BITS;
	localparam int SQ_BITS          = 2 * MAG_BITS;
	localparam int SUM_BITS         = SQ_BITS + 2;
	localparam int ROOT_BITS        = SUM_BITS / 2;
	localparam int REM_BITS         = ROOT_BITS + 2;
	localparam int DREM_BITS        = ROOT_BITS + 1;
	localparam int QUO_BITS         = NORMAL_FRAC_BITS + 1;
	localparam int DIV_STAGES       = NORMAL_FRAC_BITS + 1;
	localparam int LATENCY          = ROOT_BITS + NORMAL_FRAC_BITS + 9;

	typedef struct packed {
		logic [MAG_BITS-1:0] mag_x;
		logic [MAG_BITS-1:0] mag_y;
		logic [MAG_BITS-1:0] mag_z;
		logic                neg_x;
		logic                neg_y;
		logic                neg_z;
		logic                degen;
	} carry_t;

endpackage

>>> hdl/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle: cross product of the edges from the first
// vertex, pipelined square root of the squared length, pipelined division per component.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------
//  vertices | first_*, second_*, third_*              | start && !busy
//  normal   | normal_x/y/z, degenerate                | done, one cycle
//
//  One triangle per clock; busy stays low.
//  The pipeline holds one stage per root bit and one stage per quotient
//  bit.
//  Reset clears only the valid bits; results cannot be stalled.
module triangle_unit_normal (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [tun_pkg::COORD_BITS-1:0] first_x,
	input  logic signed [tun_pkg::COORD_BITS-1:0] first_y,
	input  logic signed [tun_pkg::COORD_BITS-1:0] first_z,
	input  logic signed [tun_pkg::COORD_BITS-1:0] second_x,
	input  logic signed [tun_pkg::COORD_BITS-1:0] second_y,
	input  logic signed [tun_pkg::COORD_BITS-1:0] second_z,
	input  logic signed [tun_pkg::COORD_BITS-1:0] third_x,
	input  logic signed [tun_pkg::COORD_BITS-1:0] third_y,
	input  logic signed [tun_pkg::COORD_BITS-1:0] third_z,
	output logic                                  done,
	output logic signed [tun_pkg::OUT_BITS-1:0]   normal_x,
	output logic signed [tun_pkg::OUT_BITS-1:0]   normal_y,
	output logic signed [tun_pkg::OUT_BITS-1:0]   normal_z,
	output logic                                  degenerate
);
	import tun_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DIFF_BITS-1:0] ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1;
	logic signed [PROD_BITS-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [CROSS_BITS-1:0] nx_s3, ny_s3, nz_s3;
	carry_t c_s4, c_s5;
	logic [SQ_BITS-1:0] qx_s5, qy_s5, qz_s5;

	logic                sq_v   [0:ROOT_BITS];
	logic [SUM_BITS-1:0] sq_rad [0:ROOT_BITS];
	logic [REM_BITS-1:0] sq_rem [0:ROOT_BITS];
	logic [ROOT_BITS-1:0] sq_root [0:ROOT_BITS];
	carry_t              sq_c   [0:ROOT_BITS];

	logic                 dv_v   [0:DIV_STAGES];
	logic [ROOT_BITS-1:0] dv_len [0:DIV_STAGES];
	logic [DREM_BITS-1:0] dv_rx  [0:DIV_STAGES];
	logic [DREM_BITS-1:0] dv_ry  [0:DIV_STAGES];
	logic [DREM_BITS-1:0] dv_rz  [0:DIV_STAGES];
	logic [QUO_BITS-1:0]  dv_qx  [0:DIV_STAGES];
	logic [QUO_BITS-1:0]  dv_qy  [0:DIV_STAGES];
	logic [QUO_BITS-1:0]  dv_qz  [0:DIV_STAGES];
	carry_t               dv_c   [0:DIV_STAGES];

	logic                 done_q;
	logic [OUT_BITS-1:0]  nx_q, ny_q, nz_q;
	logic                 degen_q;

	logic [ROOT_BITS-1:0] len_w;

	function automatic logic [OUT_BITS-1:0] finish(input logic [QUO_BITS-1:0] q,
			input logic neg, input logic degen);
		logic [OUT_BITS-1:0] m;
		m = {{(OUT_BITS-QUO_BITS){1'b0}}, q};
		if (m > (OUT_BITS'(1) << NORMAL_FRAC_BITS))
			m = OUT_BITS'(1) << NORMAL_FRAC_BITS;
		if (neg)
			m = -m;
		if (degen)
			m = '0;
		return m;
	endfunction

	assign busy = 1'b0;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			sq_v[0] <= 1'b0;
			dv_v[0] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			sq_v[0] <= v_s5;
			dv_v[0] <= sq_v[ROOT_BITS];
			done_q <= dv_v[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		ux_s1 <= DIFF_BITS'(second_x) - DIFF_BITS'(first_x);
		uy_s1 <= DIFF_BITS'(second_y) - DIFF_BITS'(first_y);
		uz_s1 <= DIFF_BITS'(second_z) - DIFF_BITS'(first_z);
		vx_s1 <= DIFF_BITS'(third_x) - DIFF_BITS'(first_x);
		vy_s1 <= DIFF_BITS'(third_y) - DIFF_BITS'(first_y);
		vz_s1 <= DIFF_BITS'(third_z) - DIFF_BITS'(first_z);

		p0_s2 <= uy_s1 * vz_s1;
		p1_s2 <= uz_s1 * vy_s1;
		p2_s2 <= uz_s1 * vx_s1;
		p3_s2 <= ux_s1 * vz_s1;
		p4_s2 <= ux_s1 * vy_s1;
		p5_s2 <= uy_s1 * vx_s1;

		nx_s3 <= CROSS_BITS'(p0_s2) - CROSS_BITS'(p1_s2);
		ny_s3 <= CROSS_BITS'(p2_s2) - CROSS_BITS'(p3_s2);
		nz_s3 <= CROSS_BITS'(p4_s2) - CROSS_BITS'(p5_s2);

		c_s4.neg_x <= nx_s3[CROSS_BITS-1];
		c_s4.neg_y <= ny_s3[CROSS_BITS-1];
		c_s4.neg_z <= nz_s3[CROSS_BITS-1];
		c_s4.mag_x <= nx_s3[CROSS_BITS-1] ? MAG_BITS'(-nx_s3) : MAG_BITS'(nx_s3);
		c_s4.mag_y <= ny_s3[CROSS_BITS-1] ? MAG_BITS'(-ny_s3) : MAG_BITS'(ny_s3);
		c_s4.mag_z <= nz_s3[CROSS_BITS-1] ? MAG_BITS'(-nz_s3) : MAG_BITS'(nz_s3);
		c_s4.degen <= (nx_s3 == '0) && (ny_s3 == '0) && (nz_s3 == '0);

		c_s5  <= c_s4;
		qx_s5 <= SQ_BITS'(c_s4.mag_x) * SQ_BITS'(c_s4.mag_x);
		qy_s5 <= SQ_BITS'(c_s4.mag_y) * SQ_BITS'(c_s4.mag_y);
		qz_s5 <= SQ_BITS'(c_s4.mag_z) * SQ_BITS'(c_s4.mag_z);

		sq_rad[0]  <= SUM_BITS'(qx_s5) + SUM_BITS'(qy_s5) + SUM_BITS'(qz_s5);
		sq_rem[0]  <= '0;
		sq_root[0] <= '0;
		sq_c[0]    <= c_s5;
	end

	genvar k;
	generate
		for (k = 0; k < ROOT_BITS; k++) begin : g_sqrt
			logic [REM_BITS-1:0] rem_w, trial_w;
			assign rem_w   = {sq_rem[k][REM_BITS-3:0], sq_rad[k][SUM_BITS-1 -: 2]};
			assign trial_w = {sq_root[k], 2'b01};
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					sq_v[k+1] <= 1'b0;
				else
					sq_v[k+1] <= sq_v[k];
			end
			always_ff @(posedge clk) begin
				sq_rad[k+1] <= sq_rad[k] << 2;
				sq_c[k+1]   <= sq_c[k];
				if (rem_w >= trial_w) begin
					sq_rem[k+1]  <= rem_w - trial_w;
					sq_root[k+1] <= {sq_root[k][ROOT_BITS-2:0], 1'b1};
				end else begin
					sq_rem[k+1]  <= rem_w;
					sq_root[k+1] <= {sq_root[k][ROOT_BITS-2:0], 1'b0};
				end
			end
		end
	endgenerate

	assign len_w = (sq_root[ROOT_BITS] == '0) ? ROOT_BITS'(1) : sq_root[ROOT_BITS];

	always_ff @(posedge clk) begin
		dv_len[0] <= len_w;
		dv_rx[0]  <= DREM_BITS'(sq_c[ROOT_BITS].mag_x);
		dv_ry[0]  <= DREM_BITS'(sq_c[ROOT_BITS].mag_y);
		dv_rz[0]  <= DREM_BITS'(sq_c[ROOT_BITS].mag_z);
		dv_qx[0]  <= '0;
		dv_qy[0]  <= '0;
		dv_qz[0]  <= '0;
		dv_c[0]   <= sq_c[ROOT_BITS];
	end

	genvar j;
	generate
		for (j = 0; j < DIV_STAGES; j++) begin : g_div
			logic [DREM_BITS-1:0] ax_w, ay_w, az_w, l_w;
			assign ax_w = (j == 0) ? dv_rx[j] : (dv_rx[j] << 1);
			assign ay_w = (j == 0) ? dv_ry[j] : (dv_ry[j] << 1);
			assign az_w = (j == 0) ? dv_rz[j] : (dv_rz[j] << 1);
			assign l_w  = DREM_BITS'(dv_len[j]);
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					dv_v[j+1] <= 1'b0;
				else
					dv_v[j+1] <= dv_v[j];
			end
			always_ff @(posedge clk) begin
				dv_len[j+1] <= dv_len[j];
				dv_c[j+1]   <= dv_c[j];
				dv_rx[j+1]  <= (ax_w >= l_w) ? ax_w - l_w : ax_w;
				dv_ry[j+1]  <= (ay_w >= l_w) ? ay_w - l_w : ay_w;
				dv_rz[j+1]  <= (az_w >= l_w) ? az_w - l_w : az_w;
				dv_qx[j+1]  <= {dv_qx[j][QUO_BITS-2:0], ax_w >= l_w};
				dv_qy[j+1]  <= {dv_qy[j][QUO_BITS-2:0], ay_w >= l_w};
				dv_qz[j+1]  <= {dv_qz[j][QUO_BITS-2:0], az_w >= l_w};
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		nx_q    <= finish(dv_qx[DIV_STAGES], dv_c[DIV_STAGES].neg_x, dv_c[DIV_STAGES].degen);
		ny_q    <= finish(dv_qy[DIV_STAGES], dv_c[DIV_STAGES].neg_y, dv_c[DIV_STAGES].degen);
		nz_q    <= finish(dv_qz[DIV_STAGES], dv_c[DIV_STAGES].neg_z, dv_c[DIV_STAGES].degen);
		degen_q <= dv_c[DIV_STAGES].degen;
	end

	assign done       = done_q;
	assign normal_x   = nx_q;
	assign normal_y   = ny_q;
	assign normal_z   = nz_q;
	assign degenerate = degen_q;

endmodule

>>> hdl/tun_checker.sv
// ----------------------------------------------------------------------------
// tun_checker
// Port-level checks of the triangle unit normal, bound to the top level.
// ----------------------------------------------------------------------------
module tun_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic                                  done,
	input logic signed [tun_pkg::OUT_BITS-1:0]   normal_x,
	input logic signed [tun_pkg::OUT_BITS-1:0]   normal_y,
	input logic signed [tun_pkg::OUT_BITS-1:0]   normal_z,
	input logic                                  degenerate
);
	import tun_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result beat missing");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate beat not zero");

	a_nondegen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
		else $error("normal lost");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.normal_x   (normal_x),
	.normal_y   (normal_y),
	.normal_z   (normal_z),
	.degenerate (degenerate)
);
